// File: rtl/cpvp_pkg.sv
// shared types and constants for the cascaded position/velocity pid core
// no dependencies; used by every module of the core
`default_nettype none

package cpvp_pkg;

	localparam int IN_W          = 32;
	localparam int GAIN_W        = 16;
	localparam int CMD_W         = 48;
	localparam int ACCEL_W       = 47;
	localparam int POS_ERR_W     = 33;
	localparam int VEL_ERR_W     = 49;
	localparam int VEL_DLT_W     = 50;
	localparam int CFG_IDX_W     = 3;
	localparam int CHUNK_W       = 32;
	localparam int ACC_WIDTH_DEF = 48;
	localparam int MAC_OP_W_DEF  = 50;

	localparam logic signed [IN_W-1:0] TARGET_RST = 32'sd20000000;
	localparam logic [GAIN_W-1:0]      KP_RST     = 16'd100;
	localparam logic [GAIN_W-1:0]      KI_RST     = 16'd10;
	localparam logic [GAIN_W-1:0]      KD_RST     = 16'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 3'd0,
		CFG_POS_KP = 3'd1,
		CFG_POS_KI = 3'd2,
		CFG_POS_KD = 3'd3,
		CFG_VEL_KP = 3'd4,
		CFG_VEL_KI = 3'd5,
		CFG_VEL_KD = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [IN_W-1:0] target_position;
		logic [GAIN_W-1:0]      pos_kp;
		logic [GAIN_W-1:0]      pos_ki;
		logic [GAIN_W-1:0]      pos_kd;
		logic [GAIN_W-1:0]      vel_kp;
		logic [GAIN_W-1:0]      vel_ki;
		logic [GAIN_W-1:0]      vel_kd;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS_ERR,
		ST_POS_MUL,
		ST_POS_SAT,
		ST_VEL_ERR,
		ST_VEL_MUL,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// File: rtl/cpvp_cfg.sv
// configuration register file: setpoint and the six loop gains
// depends on cpvp_pkg
`default_nettype none

module cpvp_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cpvp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cpvp_pkg::IN_W-1:0]        cfg_data,
	output cpvp_pkg::cfg_regs_t                   regs
);

	localparam int GW = cpvp_pkg::GAIN_W;

	cpvp_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_position <= cpvp_pkg::TARGET_RST;
			regs_q.pos_kp          <= cpvp_pkg::KP_RST;
			regs_q.pos_ki          <= cpvp_pkg::KI_RST;
			regs_q.pos_kd          <= cpvp_pkg::KD_RST;
			regs_q.vel_kp          <= cpvp_pkg::KP_RST;
			regs_q.vel_ki          <= cpvp_pkg::KI_RST;
			regs_q.vel_kd          <= cpvp_pkg::KD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cpvp_pkg::cfg_idx_t'(cfg_index))
				cpvp_pkg::CFG_TARGET: regs_q.target_position <= $signed(cfg_data);
				cpvp_pkg::CFG_POS_KP: regs_q.pos_kp <= cfg_data[GW-1:0];
				cpvp_pkg::CFG_POS_KI: regs_q.pos_ki <= cfg_data[GW-1:0];
				cpvp_pkg::CFG_POS_KD: regs_q.pos_kd <= cfg_data[GW-1:0];
				cpvp_pkg::CFG_VEL_KP: regs_q.vel_kp <= cfg_data[GW-1:0];
				cpvp_pkg::CFG_VEL_KI: regs_q.vel_ki <= cfg_data[GW-1:0];
				cpvp_pkg::CFG_VEL_KD: regs_q.vel_kd <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/cpvp_mac.sv
// shared multiply-accumulate unit: kp*e + ki*s + kd*d over one 33x17 multiplier,
// one 32-bit operand chunk per cycle; depends on cpvp_pkg
`default_nettype none

module cpvp_mac #(
	parameter int OP_W = cpvp_pkg::MAC_OP_W_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [OP_W-1:0]                op_e,
	input  wire logic signed [OP_W-1:0]                op_s,
	input  wire logic signed [OP_W-1:0]                op_d,
	input  wire logic [cpvp_pkg::GAIN_W-1:0]           gain_p,
	input  wire logic [cpvp_pkg::GAIN_W-1:0]           gain_i,
	input  wire logic [cpvp_pkg::GAIN_W-1:0]           gain_d,
	output logic signed [OP_W+cpvp_pkg::GAIN_W+1:0]    acc,
	output logic                                       done
);

	localparam int CW     = cpvp_pkg::CHUNK_W;
	localparam int GW     = cpvp_pkg::GAIN_W;
	localparam int SUM_W  = OP_W + GW + 2;
	localparam int NCH    = (OP_W + CW - 1) / CW;
	localparam int EXT_W  = NCH * CW;
	localparam int CH_IW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PP_W   = CW + 1 + GW + 1;
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;
	localparam logic [CH_IW-1:0] CH_LAST = CH_IW'(NCH - 1);

	logic                    busy_q;
	logic [1:0]              term_q;
	logic [CH_IW-1:0]        chunk_q;
	logic                    vld_s1;
	logic                    last_s1;
	logic [CH_IW-1:0]        chunk_s1;
	logic signed [PP_W-1:0]  prod_s1;
	logic signed [SUM_W-1:0] acc_q;
	logic                    done_q;

	logic signed [OP_W-1:0]  op_sel;
	logic [GW-1:0]           gain_sel;
	logic signed [EXT_W-1:0] op_ext;
	logic [CW-1:0]           chunk_raw;
	logic signed [CW:0]      chunk_op;
	logic signed [PP_W-1:0]  prod;
	logic signed [SUM_W-1:0] pp_ext;
	logic                    chunk_last;

	always_comb begin
		case (term_q)
			TERM_P: begin
				op_sel   = op_e;
				gain_sel = gain_p;
			end
			TERM_I: begin
				op_sel   = op_s;
				gain_sel = gain_i;
			end
			default: begin
				op_sel   = op_d;
				gain_sel = gain_d;
			end
		endcase
	end

	assign chunk_last = (chunk_q == CH_LAST);
	assign op_ext     = EXT_W'(op_sel);
	assign chunk_raw  = op_ext[chunk_q*CW +: CW];
	// lower chunks are unsigned digits, the top chunk carries the sign
	assign chunk_op   = $signed({chunk_last ? chunk_raw[CW-1] : 1'b0, chunk_raw});
	assign prod       = chunk_op * $signed({1'b0, gain_sel});
	assign pp_ext     = SUM_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			term_q   <= TERM_P;
			chunk_q  <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			chunk_s1 <= '0;
			done_q   <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			term_q  <= TERM_P;
			chunk_q <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q   <= vld_s1 && last_s1;
			vld_s1   <= busy_q;
			last_s1  <= busy_q && chunk_last && (term_q == TERM_D);
			chunk_s1 <= chunk_q;
			if (busy_q) begin
				if (chunk_last) begin
					chunk_q <= '0;
					if (term_q == TERM_D) begin
						busy_q <= 1'b0;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end else begin
					chunk_q <= chunk_q + CH_IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (start) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + (pp_ext <<< (chunk_s1 * CW));
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: rtl/cascaded_position_velocity_pid_core.sv
// Cascaded position/velocity PID core. Each accepted sample runs the position loop, then the
// velocity loop, on one shared 33x17 multiply-accumulate unit that takes one 32-bit operand
// chunk per cycle. After acceptance, in_ready stays low until the result appears, so each
// sample completes before the next is taken (three gain products of two chunks each per
// loop, plus setup and saturation steps). If the previous
// result is still waiting at the end of a sample, the core holds until that result is taken.
// Results sit in an output register, so a new sample is taken while the last result waits.
// Configuration writes are taken at any time but are meant for idle periods only.
// Depends on cpvp_pkg, cpvp_cfg and cpvp_mac.
`default_nettype none

module cascaded_position_velocity_pid_core #(
	parameter int ACC_WIDTH = cpvp_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [cpvp_pkg::IN_W-1:0]      measured_position,
	input  wire logic signed [cpvp_pkg::IN_W-1:0]      measured_velocity,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [cpvp_pkg::CMD_W-1:0]          speed_command,
	output logic [cpvp_pkg::ACCEL_W-1:0]               accel_command,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [cpvp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [cpvp_pkg::IN_W-1:0]             cfg_data
);

	localparam int IW    = cpvp_pkg::IN_W;
	localparam int GW    = cpvp_pkg::GAIN_W;
	localparam int CMW   = cpvp_pkg::CMD_W;
	localparam int AW    = cpvp_pkg::ACCEL_W;
	localparam int EP_W  = cpvp_pkg::POS_ERR_W;
	localparam int EV_W  = cpvp_pkg::VEL_ERR_W;
	localparam int DL_W  = cpvp_pkg::VEL_DLT_W;
	localparam int OP_W  = (ACC_WIDTH > DL_W) ? ACC_WIDTH : DL_W;
	localparam int MAC_W = OP_W + GW + 2;
	localparam int SW    = ((ACC_WIDTH > EV_W) ? ACC_WIDTH : EV_W) + 1;

	localparam logic signed [SW-1:0] SUM_MAX =
		{{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [MAC_W-1:0] CMD_MAX =
		{{(MAC_W-CMW+1){1'b0}}, {(CMW-1){1'b1}}};
	localparam logic signed [MAC_W-1:0] CMD_MIN = ~CMD_MAX;

	cpvp_pkg::cfg_regs_t regs;
	cpvp_pkg::state_t    state_q;
	cpvp_pkg::state_t    state_nx;

	logic signed [IW-1:0]        pos_in_q;
	logic signed [IW-1:0]        vel_in_q;
	logic signed [ACC_WIDTH-1:0] pos_sum_q;
	logic signed [ACC_WIDTH-1:0] vel_sum_q;
	logic signed [EP_W-1:0]      pos_prev_q;
	logic signed [EV_W-1:0]      vel_prev_q;
	logic signed [EV_W-1:0]      e_q;
	logic signed [DL_W-1:0]      d_q;
	logic signed [CMW-1:0]       speed_q;
	logic                        out_valid_q;
	logic signed [CMW-1:0]       speed_out_q;
	logic [AW-1:0]               accel_out_q;

	logic                        mac_start;
	logic                        mac_done;
	logic signed [MAC_W-1:0]     mac_acc;
	logic                        vel_phase;
	logic signed [OP_W-1:0]      mac_op_s;
	logic [GW-1:0]               gain_p;
	logic [GW-1:0]               gain_i;
	logic [GW-1:0]               gain_d;

	logic                        ld_in;
	logic                        ld_pos;
	logic                        ld_speed;
	logic                        ld_vel;
	logic                        ld_out;
	logic                        out_free;

	logic signed [EP_W-1:0]      errp;
	logic signed [EV_W-1:0]      errv;
	logic signed [EV_W-1:0]      err_sel;
	logic signed [EV_W-1:0]      prev_sel;
	logic signed [ACC_WIDTH-1:0] sum_sel;
	logic signed [SW-1:0]        sum_raw;
	logic signed [ACC_WIDTH-1:0] sum_new;
	logic signed [DL_W-1:0]      delta;
	logic signed [CMW-1:0]       speed_sat;
	logic                        acc_neg;
	logic                        accel_ovf;
	logic signed [MAC_W-1:0]     acc_abs;
	logic [AW-1:0]               accel_sat;

	cpvp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// operands of the shared unit follow the loop being worked on
	assign vel_phase = (state_q == cpvp_pkg::ST_VEL_MUL);
	assign mac_op_s  = vel_phase ? OP_W'(vel_sum_q) : OP_W'(pos_sum_q);
	assign gain_p    = vel_phase ? regs.vel_kp : regs.pos_kp;
	assign gain_i    = vel_phase ? regs.vel_ki : regs.pos_ki;
	assign gain_d    = vel_phase ? regs.vel_kd : regs.pos_kd;

	cpvp_mac #(
		.OP_W (OP_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.op_e   (OP_W'(e_q)),
		.op_s   (mac_op_s),
		.op_d   (OP_W'(d_q)),
		.gain_p (gain_p),
		.gain_i (gain_i),
		.gain_d (gain_d),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// error, saturating error sum and error delta, shared by both loops
	assign errp     = EP_W'($signed(regs.target_position)) - EP_W'(pos_in_q);
	assign errv     = EV_W'(speed_q) - EV_W'(vel_in_q);
	assign err_sel  = (state_q == cpvp_pkg::ST_VEL_ERR) ? errv : EV_W'(errp);
	assign prev_sel = (state_q == cpvp_pkg::ST_VEL_ERR) ? vel_prev_q : EV_W'(pos_prev_q);
	assign sum_sel  = (state_q == cpvp_pkg::ST_VEL_ERR) ? vel_sum_q : pos_sum_q;
	assign sum_raw  = SW'(sum_sel) + SW'(err_sel);
	assign sum_new  = (sum_raw > SUM_MAX) ? ACC_MAX :
	                  (sum_raw < SUM_MIN) ? ACC_MIN : sum_raw[ACC_WIDTH-1:0];
	assign delta    = DL_W'(err_sel) - DL_W'(prev_sel);

	assign speed_sat = (mac_acc > CMD_MAX) ? CMW'(CMD_MAX) :
	                   (mac_acc < CMD_MIN) ? CMW'(CMD_MIN) : mac_acc[CMW-1:0];

	// a magnitude of 2^47 or more clips, so the most negative command clips too
	assign acc_neg   = mac_acc[MAC_W-1];
	assign accel_ovf = acc_neg ? (mac_acc <= CMD_MIN) : (mac_acc > CMD_MAX);
	assign acc_abs   = acc_neg ? -mac_acc : mac_acc;
	assign accel_sat = accel_ovf ? {AW{1'b1}} : acc_abs[AW-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cpvp_pkg::ST_IDLE:    if (in_valid) state_nx = cpvp_pkg::ST_POS_ERR;
			cpvp_pkg::ST_POS_ERR: state_nx = cpvp_pkg::ST_POS_MUL;
			cpvp_pkg::ST_POS_MUL: if (mac_done) state_nx = cpvp_pkg::ST_POS_SAT;
			cpvp_pkg::ST_POS_SAT: state_nx = cpvp_pkg::ST_VEL_ERR;
			cpvp_pkg::ST_VEL_ERR: state_nx = cpvp_pkg::ST_VEL_MUL;
			cpvp_pkg::ST_VEL_MUL: if (mac_done) state_nx = cpvp_pkg::ST_FIN;
			cpvp_pkg::ST_FIN:     if (out_free) state_nx = cpvp_pkg::ST_IDLE;
			default:              state_nx = cpvp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == cpvp_pkg::ST_IDLE);
		ld_in     = in_ready && in_valid;
		ld_pos    = (state_q == cpvp_pkg::ST_POS_ERR);
		ld_vel    = (state_q == cpvp_pkg::ST_VEL_ERR);
		ld_speed  = (state_q == cpvp_pkg::ST_POS_SAT);
		ld_out    = (state_q == cpvp_pkg::ST_FIN) && out_free;
		mac_start = ld_pos || ld_vel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpvp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			pos_sum_q   <= '0;
			vel_sum_q   <= '0;
			pos_prev_q  <= '0;
			vel_prev_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ld_pos) begin
				pos_sum_q  <= sum_new;
				pos_prev_q <= errp;
			end
			if (ld_vel) begin
				vel_sum_q  <= sum_new;
				vel_prev_q <= errv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			pos_in_q <= measured_position;
			vel_in_q <= measured_velocity;
		end
		if (ld_pos || ld_vel) begin
			e_q <= err_sel;
			d_q <= delta;
		end
		if (ld_speed) begin
			speed_q <= speed_sat;
		end
		if (ld_out) begin
			speed_out_q <= speed_q;
			accel_out_q <= accel_sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_command = speed_out_q;
	assign accel_command = accel_out_q;

`ifndef SYNTHESIS
	a_accept_starts_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == cpvp_pkg::ST_POS_ERR)
		else $error("accepted sample did not start the position loop");

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == cpvp_pkg::ST_POS_MUL || state_q == cpvp_pkg::ST_VEL_MUL))
		else $error("multiply-accumulate finished outside a multiply phase");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cpvp_pkg::ST_FIN))
		else $error("result presented without finishing the velocity loop");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && state_q == cpvp_pkg::ST_FIN |=> state_q == cpvp_pkg::ST_FIN)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
